// ----- design/humidity_alert_limit_framer_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the alert limit framer
// Clocked property wrappers, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_ALERT_LIMIT_FRAMER_ASSERT_SVH
`define HUMIDITY_ALERT_LIMIT_FRAMER_ASSERT_SVH

// Condition must hold at every clock edge.
`define HALF_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define HALF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/half_pkg.sv -----
// ---------------------------------------------------------------------------
// half_pkg
// Constants, types and helper functions of the alert limit framer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package half_pkg;

   typedef logic [2:0] pos_type;

   localparam logic [7:0] ALERT_WRITE_CMD = 8'h61;
   localparam logic [7:0] CRC_POLY        = 8'h31;
   localparam logic [7:0] CRC_INIT        = 8'hFF;

   localparam logic [7:0] CODE_HIGH_SET   = 8'h1D;
   localparam logic [7:0] CODE_HIGH_CLEAR = 8'h16;
   localparam logic [7:0] CODE_LOW_CLEAR  = 8'h0B;
   localparam logic [7:0] CODE_LOW_SET    = 8'h00;

   localparam logic [1:0] SEL_HIGH_SET    = 2'd0;
   localparam logic [1:0] SEL_HIGH_CLEAR  = 2'd1;
   localparam logic [1:0] SEL_LOW_CLEAR   = 2'd2;
   localparam logic [1:0] SEL_LOW_SET     = 2'd3;

   localparam logic signed [15:0] T_MIN = -16'sd4500;
   localparam logic signed [15:0] T_MAX = 16'sd13000;
   localparam logic signed [15:0] H_MIN = 16'sd0;
   localparam logic signed [15:0] H_MAX = 16'sd10000;

   // Divisors for the kept code bits: 17500 * 2^7 and 10000 * 2^9.
   localparam logic [21:0] T_DIV   = 22'd2240000;
   localparam logic [22:0] H_DIV   = 23'd5120000;
   // floor(2^40 / divisor); the estimate is low by at most one.
   localparam logic [18:0] T_RECIP = 19'd490853;
   localparam logic [17:0] H_RECIP = 18'd214748;
   localparam int          RECIP_SHIFT = 40;

   localparam pos_type POS_CMD  = 3'd0;
   localparam pos_type POS_CODE = 3'd1;
   localparam pos_type POS_MSB  = 3'd2;
   localparam pos_type POS_LSB  = 3'd3;
   localparam pos_type POS_CRC  = 3'd4;

   function automatic logic [7:0] limit_code(input logic [1:0] sel);
      logic [7:0] code;
      case (sel)
         SEL_HIGH_SET:   code = CODE_HIGH_SET;
         SEL_HIGH_CLEAR: code = CODE_HIGH_CLEAR;
         SEL_LOW_CLEAR:  code = CODE_LOW_CLEAR;
         SEL_LOW_SET:    code = CODE_LOW_SET;
         default:        code = CODE_LOW_SET;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] crc_step(input logic [7:0] crc_val,
                                           input logic [7:0] data);
      logic [7:0] c;
      c = crc_val ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- design/humidity_alert_limit_framer.sv -----
// ---------------------------------------------------------------------------
// humidity_alert_limit_framer
// Clamps and scales one alert limit, packs the limit word, appends CRC-8
// and streams the five-byte write frame.
// ---------------------------------------------------------------------------
// Channel  | Ports                                  | Direction
// req      | req_which_limit, req_temp_centi,       | in  (stall out)
//          | req_hum_centi                          |
// rsp      | rsp_frame_byte, rsp_last_byte          | out (stall in)
//
// Six register stages (clamp, x65535, reciprocal estimate, correction,
// CRC of MSB, CRC of LSB) feed a byte serializer. The first byte of a
// frame is offered once its transaction has passed all the stages and has
// been loaded into the serializer, which sends one byte per cycle while
// rsp_stall is low and loads the next frame as the last byte is taken.
// Reset clears the stage valid bits and the serializer; no clearing pass.
// rsp_stall holds the current byte; the stages keep filling behind it until
// all are occupied, then req_stall rises.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_alert_limit_framer_assert.svh"

module humidity_alert_limit_framer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_which_limit,
   input  logic signed [15:0] req_temp_centi,
   input  logic signed [15:0] req_hum_centi,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte
);

   // stage valid bits and load enables
   logic [6:1] vld_ff, vld_in;
   logic [7:1] en;

   // serializer
   logic                 busy_ff, busy_in;
   half_pkg::pos_type    pos_ff, pos_in;
   logic [7:0]           ser_code_ff, ser_msb_ff, ser_lsb_ff, ser_crc_ff;
   logic                 ser_free;
   logic                 rsp_fire;

   // stage 1: clamp and offset
   logic [7:0]           s1_code_ff, s1_code_in;
   logic [14:0]          s1_t_ff, s1_t_in;
   logic [13:0]          s1_h_ff, s1_h_in;
   logic signed [15:0]   t_cl, h_cl;
   logic [15:0]          t_sum;

   // stage 2: times 65535
   logic [7:0]           s2_code_ff;
   logic [30:0]          s2_pt_ff, s2_pt_in;
   logic [29:0]          s2_ph_ff, s2_ph_in;

   // stage 3: reciprocal estimate
   logic [7:0]           s3_code_ff;
   logic [30:0]          s3_pt_ff;
   logic [29:0]          s3_ph_ff;
   logic [8:0]           s3_qt_ff, s3_qt_in;
   logic [6:0]           s3_qh_ff, s3_qh_in;
   logic [49:0]          prod_t;
   logic [47:0]          prod_h;

   // stage 4: correction
   logic [7:0]           s4_code_ff;
   logic [8:0]           s4_qt_ff, s4_qt_in;
   logic [6:0]           s4_qh_ff, s4_qh_in;
   logic [30:0]          rem_t;
   logic [29:0]          rem_h;

   // stage 5: pack and CRC of MSB
   logic [7:0]           s5_code_ff, s5_msb_ff, s5_lsb_ff, s5_crc_ff;
   logic [7:0]           s5_msb_in, s5_crc_in;

   // stage 6: CRC of LSB
   logic [7:0]           s6_code_ff, s6_msb_ff, s6_lsb_ff, s6_crc_ff, s6_crc_in;

   // -----------------------------------------------------------------------
   // flow control: a stage loads when it is empty or its content moves on
   // -----------------------------------------------------------------------
   assign rsp_fire = busy_ff && !rsp_stall;
   assign ser_free = !busy_ff || (rsp_fire && (pos_ff == half_pkg::POS_CRC));

   always_comb begin
      en[7] = ser_free;
      for (int k = 6; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[1] = req_valid;
      for (int k = 2; k <= 6; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_stall = !en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= 6; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // stage 1
   // -----------------------------------------------------------------------
   always_comb begin
      if (req_temp_centi < half_pkg::T_MIN) begin
         t_cl = half_pkg::T_MIN;
      end else if (req_temp_centi > half_pkg::T_MAX) begin
         t_cl = half_pkg::T_MAX;
      end else begin
         t_cl = req_temp_centi;
      end
      if (req_hum_centi < half_pkg::H_MIN) begin
         h_cl = half_pkg::H_MIN;
      end else if (req_hum_centi > half_pkg::H_MAX) begin
         h_cl = half_pkg::H_MAX;
      end else begin
         h_cl = req_hum_centi;
      end
      t_sum      = 16'(unsigned'(t_cl) - unsigned'(half_pkg::T_MIN));
      s1_t_in    = t_sum[14:0];
      s1_h_in    = h_cl[13:0];
      s1_code_in = half_pkg::limit_code(req_which_limit);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_code_ff <= s1_code_in;
         s1_t_ff    <= s1_t_in;
         s1_h_ff    <= s1_h_in;
      end
   end

   // -----------------------------------------------------------------------
   // stage 2: x * 65535 = (x << 16) - x
   // -----------------------------------------------------------------------
   assign s2_pt_in = {s1_t_ff, 16'd0} - 31'(s1_t_ff);
   assign s2_ph_in = {s1_h_ff, 16'd0} - 30'(s1_h_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_code_ff <= s1_code_ff;
         s2_pt_ff   <= s2_pt_in;
         s2_ph_ff   <= s2_ph_in;
      end
   end

   // -----------------------------------------------------------------------
   // stage 3: quotient estimate by reciprocal multiply
   // -----------------------------------------------------------------------
   assign prod_t   = 50'(s2_pt_ff) * 50'(half_pkg::T_RECIP);
   assign prod_h   = 48'(s2_ph_ff) * 48'(half_pkg::H_RECIP);
   assign s3_qt_in = prod_t[half_pkg::RECIP_SHIFT +: 9];
   assign s3_qh_in = prod_h[half_pkg::RECIP_SHIFT +: 7];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_code_ff <= s2_code_ff;
         s3_pt_ff   <= s2_pt_ff;
         s3_ph_ff   <= s2_ph_ff;
         s3_qt_ff   <= s3_qt_in;
         s3_qh_ff   <= s3_qh_in;
      end
   end

   // -----------------------------------------------------------------------
   // stage 4: bump the estimate when the remainder reaches the divisor
   // -----------------------------------------------------------------------
   always_comb begin
      rem_t    = s3_pt_ff - 31'(31'(s3_qt_ff) * 31'(half_pkg::T_DIV));
      rem_h    = s3_ph_ff - 30'(30'(s3_qh_ff) * 30'(half_pkg::H_DIV));
      s4_qt_in = (rem_t >= 31'(half_pkg::T_DIV)) ? 9'(s3_qt_ff + 9'd1) : s3_qt_ff;
      s4_qh_in = (rem_h >= 30'(half_pkg::H_DIV)) ? 7'(s3_qh_ff + 7'd1) : s3_qh_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_code_ff <= s3_code_ff;
         s4_qt_ff   <= s4_qt_in;
         s4_qh_ff   <= s4_qh_in;
      end
   end

   // -----------------------------------------------------------------------
   // stage 5: humidity bits 15..9 over temperature bits 15..7
   // -----------------------------------------------------------------------
   assign s5_msb_in = {s4_qh_ff, s4_qt_ff[8]};
   assign s5_crc_in = half_pkg::crc_step(half_pkg::CRC_INIT, s5_msb_in);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_code_ff <= s4_code_ff;
         s5_msb_ff  <= s5_msb_in;
         s5_lsb_ff  <= s4_qt_ff[7:0];
         s5_crc_ff  <= s5_crc_in;
      end
   end

   // -----------------------------------------------------------------------
   // stage 6
   // -----------------------------------------------------------------------
   assign s6_crc_in = half_pkg::crc_step(s5_crc_ff, s5_lsb_ff);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_code_ff <= s5_code_ff;
         s6_msb_ff  <= s5_msb_ff;
         s6_lsb_ff  <= s5_lsb_ff;
         s6_crc_ff  <= s6_crc_in;
      end
   end

   // -----------------------------------------------------------------------
   // byte serializer
   // -----------------------------------------------------------------------
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (ser_free) begin
         // load the next frame, or drop to idle
         busy_in = vld_ff[6];
         pos_in  = half_pkg::POS_CMD;
      end else if (rsp_fire) begin
         pos_in  = 3'(pos_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= half_pkg::POS_CMD;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_free && vld_ff[6]) begin
         ser_code_ff <= s6_code_ff;
         ser_msb_ff  <= s6_msb_ff;
         ser_lsb_ff  <= s6_lsb_ff;
         ser_crc_ff  <= s6_crc_ff;
      end
   end

   always_comb begin
      case (pos_ff)
         half_pkg::POS_CMD:  rsp_frame_byte = half_pkg::ALERT_WRITE_CMD;
         half_pkg::POS_CODE: rsp_frame_byte = ser_code_ff;
         half_pkg::POS_MSB:  rsp_frame_byte = ser_msb_ff;
         half_pkg::POS_LSB:  rsp_frame_byte = ser_lsb_ff;
         half_pkg::POS_CRC:  rsp_frame_byte = ser_crc_ff;
         default:            rsp_frame_byte = ser_crc_ff;
      endcase
   end

   assign rsp_valid     = busy_ff;
   assign rsp_last_byte = (pos_ff == half_pkg::POS_CRC);

   // -----------------------------------------------------------------------
   // assertions
   // -----------------------------------------------------------------------
   `HALF_ASSERT_NEXT(a_load_starts_frame, clock, reset, ser_free && vld_ff[6], rsp_valid && (pos_ff == half_pkg::POS_CMD), "loaded frame does not start at the command byte")
   `HALF_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_fire && rsp_last_byte && !vld_ff[6], !rsp_valid, "serializer stays busy after last byte with nothing queued")
   `HALF_ASSERT_NEXT(a_stage6_holds, clock, reset, vld_ff[6] && !ser_free, vld_ff[6] && $stable(s6_crc_ff) && $stable(s6_lsb_ff), "stage six lost or changed a held frame")
   `HALF_ASSERT_ALWAYS(a_pos_range, clock, reset, !busy_ff || (pos_ff <= half_pkg::POS_CRC), "byte position beyond the frame")

endmodule
